FILE: rtl/core/byte_stuffing_deframer_unit_macros.svh
// Assertion macros for the byte stuffing deframer.
`ifndef BYTE_STUFFING_DEFRAMER_UNIT_MACROS_SVH
`define BYTE_STUFFING_DEFRAMER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define BSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `BSD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define BSD_ASSERT(lbl, clk, rstn, prop, msg)
`define BSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/core/bsd_pkg.sv
// Types and constants shared by the byte stuffing deframer files.
package bsd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_FE  = 8'hFE;
  localparam logic [7:0] STUFF_ZERO = 8'h00;
  localparam logic [1:0] RUN_PAIR = 2'd2;

endpackage

FILE: rtl/core/bsd_if.sv
// Stream interfaces for the received byte channel and the result channel.
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsd_out_if;
  logic                valid;
  logic                ready;
  bsd_pkg::kind_t      kind;
  logic [7:0]          data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

FILE: rtl/core/byte_stuffing_deframer_unit.sv
// Byte stuffing deframer: marker run tracking, two-byte hold line, skid output.
//
//   channel   dir  payload               transfer when
//   in_ch     in   rx_byte[7:0]          valid && ready
//   out_ch    out  kind[1:0], data[7:0]  valid && ready
//
// One byte per cycle while in_ch.ready is high; the decision for a byte is made in
// the cycle it transfers; its result (if any) is registered in out_r or the skid entry.
// Data bytes trail the input by two kept bytes (the hold line).
// rst_n is synchronous: runs cleared, hold line empty, outside any frame.
// A two-entry output buffer keeps in_ch.ready high for one stalled result;
// ready drops only while the skid entry is occupied.
`include "byte_stuffing_deframer_unit_macros.svh"

module byte_stuffing_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  bsd_in_if.sink     in_ch,
  bsd_out_if.source  out_ch
);

  typedef struct packed {
    logic       v0;
    logic [7:0] b0;
    logic       v1;
    logic [7:0] b1;
  } line_t;

  typedef struct packed {
    line_t      line;
    logic       leave_v;
    logic [7:0] leave;
  } push_t;

  typedef struct packed {
    logic           valid;
    bsd_pkg::kind_t kind;
    logic [7:0]     data;
  } res_t;

  function automatic push_t push(line_t l, logic [7:0] b);
    push_t p;
    p.line    = l;
    p.leave_v = 1'b0;
    p.leave   = l.b0;
    if (!l.v0) begin
      p.line.v0 = 1'b1;
      p.line.b0 = b;
    end else if (!l.v1) begin
      p.line.v1 = 1'b1;
      p.line.b1 = b;
    end else begin
      p.leave_v = 1'b1;
      p.line.b0 = l.b1;
      p.line.b1 = b;
    end
    return p;
  endfunction

  logic [1:0] ff_run_r, ff_run_nxt;
  logic [1:0] fe_run_r, fe_run_nxt;
  line_t      line_r, line_nxt;
  logic       in_frame_r, in_frame_nxt;
  res_t       out_r, skid_r, res;

  logic       accept;
  logic       pop;
  logic [7:0] b;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_r.valid && out_ch.ready;
  assign b      = in_ch.rx_byte;

  assign in_ch.ready      = !skid_r.valid;
  assign out_ch.valid     = out_r.valid;
  assign out_ch.kind      = out_r.kind;
  assign out_ch.data_byte = out_r.data;

  always_comb begin
    logic       pair;
    logic [7:0] m;
    logic       do_tail;
    line_t      base;
    logic [1:0] base_ff;
    logic [1:0] base_fe;
    push_t      p;

    pair    = (ff_run_r == bsd_pkg::RUN_PAIR) || (fe_run_r == bsd_pkg::RUN_PAIR);
    m       = (ff_run_r == bsd_pkg::RUN_PAIR) ? bsd_pkg::MARK_FF : bsd_pkg::MARK_FE;
    do_tail = 1'b1;
    base    = line_r;
    base_ff = ff_run_r;
    base_fe = fe_run_r;
    p       = push(line_r, b);

    ff_run_nxt   = ff_run_r;
    fe_run_nxt   = fe_run_r;
    line_nxt     = line_r;
    in_frame_nxt = in_frame_r;
    res.valid    = 1'b0;
    res.kind     = bsd_pkg::KIND_DATA;
    res.data     = 8'h00;

    if (pair) begin
      ff_run_nxt = 2'd0;
      fe_run_nxt = 2'd0;
      base_ff    = 2'd0;
      base_fe    = 2'd0;
      if (b == bsd_pkg::STUFF_ZERO) begin
        // stuffed zero: keep the marker, drop the zero
        do_tail   = 1'b0;
        p         = push(line_r, m);
        line_nxt  = p.line;
        res.valid = p.leave_v && in_frame_r;
        res.data  = p.leave;
      end else if (b == m) begin
        do_tail  = 1'b0;
        line_nxt = '0;
        if (m == bsd_pkg::MARK_FF) begin
          in_frame_nxt = 1'b1;
          res.valid    = 1'b1;
          res.kind     = bsd_pkg::KIND_START;
        end else if (in_frame_r) begin
          in_frame_nxt = 1'b0;
          res.valid    = 1'b1;
          res.kind     = bsd_pkg::KIND_END;
        end
      end else if (!(line_r.v0 && line_r.v1)) begin
        // malformed pair: marker kept only if the line has room
        p    = push(line_r, m);
        base = p.line;
      end
    end

    if (do_tail) begin
      ff_run_nxt = (b == bsd_pkg::MARK_FF) ? base_ff + 2'd1 : 2'd0;
      fe_run_nxt = (b == bsd_pkg::MARK_FE) ? base_fe + 2'd1 : 2'd0;
      if (ff_run_nxt == bsd_pkg::RUN_PAIR || fe_run_nxt == bsd_pkg::RUN_PAIR) begin
        line_nxt = base;   // second marker held back until the next byte
      end else begin
        p         = push(base, b);
        line_nxt  = p.line;
        res.valid = p.leave_v && in_frame_r;
        res.data  = p.leave;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_run_r     <= 2'd0;
      fe_run_r     <= 2'd0;
      line_r.v0    <= 1'b0;
      line_r.v1    <= 1'b0;
      in_frame_r   <= 1'b0;
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      if (accept) begin
        ff_run_r   <= ff_run_nxt;
        fe_run_r   <= fe_run_nxt;
        line_r     <= line_nxt;
        in_frame_r <= in_frame_nxt;
      end
      if (!out_r.valid || pop) begin
        if (skid_r.valid) begin
          out_r        <= skid_r;
          skid_r.valid <= 1'b0;
        end else begin
          out_r.valid <= accept && res.valid;
          out_r.kind  <= res.kind;
          out_r.data  <= res.data;
        end
      end else if (accept && res.valid) begin
        skid_r <= res;
      end
    end
  end

  `BSD_ASSERT(a_skid_behind_out, clk, rst_n, skid_r.valid |-> out_r.valid,
              "skid entry occupied while output register empty")
  `BSD_ASSERT_NEVER(a_runs_exclusive, clk, rst_n, (ff_run_r != 2'd0) && (fe_run_r != 2'd0),
                    "0xFF and 0xFE runs counted at once")
  `BSD_ASSERT(a_line_order, clk, rst_n, line_r.v1 |-> line_r.v0,
              "newer hold entry valid without older entry")
  `BSD_ASSERT(a_frame_start, clk, rst_n,
              $rose(in_frame_r) |-> $past(accept && (b == bsd_pkg::MARK_FF)),
              "frame entered without a 0xFF transfer")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the byte stuffing deframer unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 80;

  typedef struct packed {
    bsd_pkg::kind_t kind;
    logic [7:0]     data;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bsd_in_if  rx_bus ();
  bsd_out_if res_bus ();

  byte_stuffing_deframer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_bus.sink),
    .out_ch (res_bus.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bytes waiting to be offered, and decoded results still owed by the unit
  logic [7:0]    rx_stream_q[$];
  frame_result_t decoded_q[$];

  // Shadow deframer state
  logic [1:0] ff_seen;
  logic [1:0] fe_seen;
  logic [8:0] delay_line[2];
  logic       framed;

  int  err_cnt;
  int  cycle_cnt;
  int  queued_bytes;
  int  tx_wait;
  int  rx_wait;
  int  rx_hold;
  bit  calm;
  bit  hold_req;
  bit  rx_took;
  bit  res_took;

  function automatic void owe_result(bsd_pkg::kind_t k, logic [7:0] d);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    decoded_q.push_back(r);
  endfunction

  function automatic void line_push(logic [7:0] b);
    logic [7:0] leaving;
    if (!delay_line[0][8]) begin
      delay_line[0] = {1'b1, b};
    end else if (!delay_line[1][8]) begin
      delay_line[1] = {1'b1, b};
    end else begin
      leaving       = delay_line[0][7:0];
      delay_line[0] = delay_line[1];
      delay_line[1] = {1'b1, b};
      if (framed) owe_result(bsd_pkg::KIND_DATA, leaving);
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] mark;
    if (ff_seen == bsd_pkg::RUN_PAIR || fe_seen == bsd_pkg::RUN_PAIR) begin
      mark    = (ff_seen == bsd_pkg::RUN_PAIR) ? bsd_pkg::MARK_FF : bsd_pkg::MARK_FE;
      ff_seen = 2'd0;
      fe_seen = 2'd0;
      if (b == bsd_pkg::STUFF_ZERO) begin
        line_push(mark);
        return;
      end
      if (b == mark) begin
        delay_line[0] = '0;
        delay_line[1] = '0;
        if (mark == bsd_pkg::MARK_FF) begin
          framed = 1'b1;
          owe_result(bsd_pkg::KIND_START, 8'h00);
        end else if (framed) begin
          framed = 1'b0;
          owe_result(bsd_pkg::KIND_END, 8'h00);
        end
        return;
      end
      // malformed pair: held marker survives only if the line has room
      if (!(delay_line[0][8] && delay_line[1][8])) line_push(mark);
    end
    ff_seen = (b == bsd_pkg::MARK_FF) ? ff_seen + 2'd1 : 2'd0;
    fe_seen = (b == bsd_pkg::MARK_FE) ? fe_seen + 2'd1 : 2'd0;
    if (ff_seen == bsd_pkg::RUN_PAIR || fe_seen == bsd_pkg::RUN_PAIR) return;
    line_push(b);
  endfunction

  task automatic log_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Sender: offers bytes at falling edges, with random gaps after transfers unless calm
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_took || !rx_bus.valid) begin
        if (rx_took) tx_wait = calm ? 0 : $urandom_range(0, 6);
        if (tx_wait > 0) begin
          tx_wait--;
          rx_bus.valid <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          rx_bus.valid   <= 1'b1;
          rx_bus.rx_byte <= rx_stream_q.pop_front();
        end else begin
          rx_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall after each transfer unless calm, plus one long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        rx_hold  = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (res_took) rx_wait = calm ? 0 : $urandom_range(0, 6);
      if (rx_hold > 0) begin
        rx_hold--;
        res_bus.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    frame_result_t want;
    cycle_cnt++;
    rx_took  = rst_n && rx_bus.valid && rx_bus.ready;
    res_took = rst_n && res_bus.valid && res_bus.ready;
    if (res_took) begin
      if (decoded_q.size() == 0) begin
        log_error($sformatf("unexpected result kind %0d data %02h",
                            res_bus.kind, res_bus.data_byte));
      end else begin
        want = decoded_q.pop_front();
        if (res_bus.kind !== want.kind)
          log_error($sformatf("kind: expected %0d got %0d", want.kind, res_bus.kind));
        if (res_bus.data_byte !== want.data)
          log_error($sformatf("data_byte: expected %02h got %02h",
                              want.data, res_bus.data_byte));
      end
    end
    if (rx_took) deframe_byte(rx_bus.rx_byte);
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_byte(logic [7:0] b);
    rx_stream_q.push_back(b);
    queued_bytes++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return bsd_pkg::MARK_FF;
      3, 4:    return bsd_pkg::MARK_FE;
      5:       return bsd_pkg::STUFF_ZERO;
      default: return 8'($urandom);
    endcase
  endfunction

  // Start sequence, stuffed payload, optional end sequence
  task automatic send_frame(int len, bit closed);
    logic [7:0] p;
    logic [7:0] run_val;
    int         run_len;
    run_val = bsd_pkg::STUFF_ZERO;
    run_len = 0;
    repeat (3) queue_byte(bsd_pkg::MARK_FF);
    for (int i = 0; i < len; i++) begin
      p = pick_byte();
      queue_byte(p);
      if (p == bsd_pkg::MARK_FF || p == bsd_pkg::MARK_FE) begin
        run_len = (p == run_val) ? run_len + 1 : 1;
        run_val = p;
        if (run_len == 2) begin
          queue_byte(bsd_pkg::STUFF_ZERO);
          run_len = 0;
        end
      end else begin
        run_len = 0;
      end
    end
    if (closed) begin
      queue_byte(bsd_pkg::STUFF_ZERO);
      repeat (3) queue_byte(bsd_pkg::MARK_FE);
    end
  endtask

  task automatic queue_mix(int n);
    int         goal;
    logic [7:0] mark;
    logic [7:0] b;
    goal = queued_bytes + n;
    while (queued_bytes < goal) begin
      case ($urandom_range(0, 9))
        6: send_frame($urandom_range(1, 8), 1'b0);
        7: repeat ($urandom_range(1, 6)) queue_byte(pick_byte());
        8: begin
          mark = $urandom_range(0, 1) ? bsd_pkg::MARK_FF : bsd_pkg::MARK_FE;
          do b = 8'($urandom); while (b == bsd_pkg::STUFF_ZERO || b == mark);
          queue_byte(mark);
          queue_byte(mark);
          queue_byte(b);
        end
        9: repeat (3) queue_byte(bsd_pkg::MARK_FE);
        default: send_frame($urandom_range(0, 12), 1'b1);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (rx_stream_q.size() != 0 || rx_bus.valid || decoded_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [7:0] opening[];
    opening = '{
      bsd_pkg::MARK_FE, bsd_pkg::MARK_FE, bsd_pkg::MARK_FE,     // end while outside a frame
      bsd_pkg::MARK_FF, bsd_pkg::MARK_FF, bsd_pkg::MARK_FF,     // frame start
      8'h00, 8'h80, 8'h7F,
      bsd_pkg::MARK_FF, bsd_pkg::MARK_FF, bsd_pkg::STUFF_ZERO,  // stuffed 0xFF
      bsd_pkg::MARK_FE, bsd_pkg::MARK_FE, 8'h55,                // bad pair, full line
      bsd_pkg::MARK_FF, bsd_pkg::MARK_FF, bsd_pkg::MARK_FF,     // restart inside a frame
      bsd_pkg::MARK_FF, bsd_pkg::MARK_FF, 8'h01,                // bad pair, empty line
      bsd_pkg::STUFF_ZERO, bsd_pkg::MARK_FE, bsd_pkg::MARK_FE, bsd_pkg::MARK_FE
    };
    rst_n          = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    res_bus.ready  = 1'b0;
    ff_seen        = 2'd0;
    fe_seen        = 2'd0;
    delay_line[0]  = '0;
    delay_line[1]  = '0;
    framed         = 1'b0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    queued_bytes   = 0;
    tx_wait        = 0;
    rx_wait        = 0;
    rx_hold        = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    rx_took        = 1'b0;
    res_took       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) queue_byte(opening[i]);
    // wait until every queued byte is sent and every owed result is out
    wait_drained();

    queue_mix(320);
    while (rx_stream_q.size() > 200) @(posedge clk);
    hold_req = 1'b1;
    wait_drained();

    calm = 1'b1;
    queue_mix(310);
    wait_drained();
    calm = 1'b0;

    queue_mix(320);
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: byte_stuffing_deframer_unit.f
+incdir+rtl/core
rtl/core/bsd_pkg.sv
rtl/core/bsd_if.sv
rtl/core/byte_stuffing_deframer_unit.sv
tb/sv/tb.sv
